// ===== src/gfbar_pkg.sv =====
// Package for the fat-binary arch rewriter: widths, phase codes, result kinds, status codes.
// Used by every module under src.
package gfbar_pkg;
    localparam int unsigned MAX_IMAGE_BYTES_DEF = 67108864;
    localparam int unsigned POS_W = 27;
    localparam int unsigned CNT_W = 22;
    localparam int unsigned NCNT = 9;
    localparam logic [31:0] IMG_MAGIC = 32'hBA55ED50;

    typedef enum logic [2:0] {
        PH_HDR    = 3'd0,
        PH_HDRPAD = 3'd1,
        PH_ENTRY  = 3'd2,
        PH_DATA   = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_CNT  = 2'd1;
    localparam logic [1:0] KIND_STAT = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_MAGIC   = 3'd2;
    localparam logic [2:0] ST_HSIZE   = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;
    localparam logic [2:0] ST_ENTRY   = 3'd5;
    localparam logic [2:0] ST_NOENT   = 3'd6;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_SRC  = 3'd1;
    localparam logic [2:0] REG_TGT  = 3'd2;
    localparam logic [2:0] REG_ELF  = 3'd3;
    localparam logic [2:0] REG_A    = 3'd4;
    localparam logic [2:0] REG_B    = 3'd5;
    localparam logic [2:0] REG_C    = 3'd6;
    localparam logic [2:0] REG_D    = 3'd7;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] src;
        logic [31:0] tgt;
        logic [31:0] elf;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_cfg;

    // Work handed from the parser to the output sequencer.
    typedef struct packed {
        logic        valid;
        logic [2:0]  nbytes;
        logic [31:0] bytes;
        logic        report;
        logic [2:0]  status;
    } t_job;
endpackage

// ===== src/gfbar_regs.sv =====
// APB register file for the rewriter configuration.
// Depends on gfbar_pkg.
module gfbar_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output gfbar_pkg::t_cfg     o_cfg
);
    gfbar_pkg::t_cfg r_cfg;
    logic [2:0] w_idx;
    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                gfbar_pkg::REG_MODE: r_cfg.mode <= pwdata[1:0];
                gfbar_pkg::REG_SRC:  r_cfg.src  <= pwdata;
                gfbar_pkg::REG_TGT:  r_cfg.tgt  <= pwdata;
                gfbar_pkg::REG_ELF:  r_cfg.elf  <= pwdata;
                gfbar_pkg::REG_A:    r_cfg.a    <= pwdata;
                gfbar_pkg::REG_B:    r_cfg.b    <= pwdata;
                gfbar_pkg::REG_C:    r_cfg.c    <= pwdata;
                default:             r_cfg.d    <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            gfbar_pkg::REG_MODE: prdata = {30'd0, r_cfg.mode};
            gfbar_pkg::REG_SRC:  prdata = r_cfg.src;
            gfbar_pkg::REG_TGT:  prdata = r_cfg.tgt;
            gfbar_pkg::REG_ELF:  prdata = r_cfg.elf;
            gfbar_pkg::REG_A:    prdata = r_cfg.a;
            gfbar_pkg::REG_B:    prdata = r_cfg.b;
            gfbar_pkg::REG_C:    prdata = r_cfg.c;
            default:             prdata = r_cfg.d;
        endcase
    end
endmodule

// ===== src/gfbar_parser.sv =====
// Byte parser: header and entry walk, arch rewrite, ELF stamp, counters and final status.
// Depends on gfbar_pkg; produces at most one job per accepted byte for gfbar_emit.
module gfbar_parser #(
    parameter int unsigned MAX_IMAGE_BYTES = gfbar_pkg::MAX_IMAGE_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_byte,
    input  logic                 i_eob,
    input  gfbar_pkg::t_cfg      i_cfg,
    input  logic                 i_clr_cnt,
    output gfbar_pkg::t_job      o_job,
    output logic [gfbar_pkg::NCNT*gfbar_pkg::CNT_W-1:0] o_cnt
);
    localparam int unsigned PW = gfbar_pkg::POS_W;
    localparam int unsigned CW = gfbar_pkg::CNT_W;
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

    gfbar_pkg::t_phase r_phase, n_phase;
    logic [PW-1:0] r_pos, n_pos, r_total, n_total, r_cursor, n_cursor;
    logic [PW-1:0] r_dstart, n_dstart, r_nb, n_nb;
    logic [10:0]   r_off, n_off;
    logic [63:0]   r_ef, n_ef;
    logic [31:0]   r_ds, n_ds;
    logic [23:0]   r_held, n_held;
    logic [1:0]    r_fl, n_fl;
    logic [63:0]   r_hlo, n_hlo;
    logic [36:0]   r_hpay, n_hpay;   // payload bits 36 and above fold into a sticky top bit
    logic [8:0]    r_hsz, n_hsz;
    logic [2:0]    r_st, n_st;
    logic [CW-1:0] r_cnt [gfbar_pkg::NCNT];
    logic [gfbar_pkg::NCNT-1:0] w_bump;
    gfbar_pkg::t_job n_job;

    // Wide helper values for the entry checks.
    logic [32:0] w_rem, w_eh, w_dsum;
    logic [34:0] w_end;
    logic [31:0] w_arch, w_out_arch, w_d;
    logic [15:0] w_kind;
    logic        w_retgt;
    logic [7:0]  w_b;
    logic [2:0]  w_fst;
    logic [PW-1:0] w_pos1;

    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_total = r_total; n_cursor = r_cursor;
        n_dstart = r_dstart; n_nb = r_nb; n_off = r_off; n_ef = r_ef; n_ds = r_ds;
        n_held = r_held; n_fl = r_fl; n_hlo = r_hlo; n_hpay = r_hpay; n_hsz = r_hsz;
        n_st = r_st; w_bump = '0;
        n_job = '0;
        w_b = i_byte;
        w_rem = {6'd0, r_total} - {6'd0, r_cursor};
        w_eh = '0; w_dsum = '0; w_end = '0; w_arch = '0; w_out_arch = '0; w_d = '0;
        w_kind = r_ef[15:0]; w_retgt = 1'b0; w_fst = gfbar_pkg::ST_OK;
        w_pos1 = r_pos + ((r_pos != POS_MAX) ? {{(PW-1){1'b0}}, 1'b1} : '0);
        n_pos = w_pos1;
        if (i_take && r_st == gfbar_pkg::ST_OK) begin
            unique case (r_phase)
                gfbar_pkg::PH_HDR: begin
                    if (r_pos < PW'(8)) begin
                        n_hlo[8*r_pos[2:0] +: 8] = i_byte;
                    end else begin
                        if (r_pos[2:0] < 3'd4) n_hpay[8*r_pos[1:0] +: 8] = i_byte;
                        else if (r_pos[2:0] == 3'd4) n_hpay[36:32] = {|i_byte[7:4], i_byte[3:0]};
                        else n_hpay[36] = r_hpay[36] | (|i_byte);
                    end
                    if (r_pos == PW'(3) && n_hlo[31:0] != gfbar_pkg::IMG_MAGIC) begin
                        n_st = gfbar_pkg::ST_MAGIC;
                    end else if (r_pos == PW'(7)) begin
                        if (n_hlo[63:48] < 16'h10 || n_hlo[63:48] > 16'h100)
                            n_st = gfbar_pkg::ST_HSIZE;
                        else begin
                            n_hsz = n_hlo[56:48];
                            n_job.valid = 1'b1; n_job.nbytes = 3'd1; n_job.bytes[7:0] = w_b;
                        end
                    end else if (r_pos == PW'(15)) begin
                        if (n_hpay > 37'(MAX_IMAGE_BYTES)) n_st = gfbar_pkg::ST_HSIZE;
                        else begin
                            n_total = PW'(n_hpay) + PW'(r_hsz);
                            n_job.valid = 1'b1; n_job.nbytes = 3'd1; n_job.bytes[7:0] = w_b;
                            if (r_hsz == 9'd16) begin
                                n_cursor = PW'(16); n_off = '0; n_ef = '0; n_ds = '0;
                                n_held = '0; n_fl = '0;
                                n_phase = (PW'(16) >= n_total) ? gfbar_pkg::PH_DONE
                                                                : gfbar_pkg::PH_ENTRY;
                            end else n_phase = gfbar_pkg::PH_HDRPAD;
                        end
                    end else begin
                        n_job.valid = 1'b1; n_job.nbytes = 3'd1; n_job.bytes[7:0] = w_b;
                    end
                end
                gfbar_pkg::PH_HDRPAD: begin
                    n_job.valid = 1'b1; n_job.nbytes = 3'd1; n_job.bytes[7:0] = w_b;
                    if ({1'b0, r_pos} + 1 >= {1'b0, PW'(r_hsz)}) begin
                        n_cursor = PW'(r_hsz); n_off = '0; n_ef = '0; n_ds = '0;
                        n_held = '0; n_fl = '0;
                        n_phase = (PW'(r_hsz) >= r_total) ? gfbar_pkg::PH_DONE
                                                           : gfbar_pkg::PH_ENTRY;
                    end
                end
                gfbar_pkg::PH_ENTRY: begin
                    if (r_off == 11'd0 && w_rem < 33'h20) begin
                        n_st = gfbar_pkg::ST_ENTRY;
                    end else begin
                        if (r_off < 11'd8) n_ef[8*r_off[2:0] +: 8] = i_byte;
                        else if (r_off < 11'd12) n_ds[8*r_off[1:0] +: 8] = i_byte;
                        w_eh = {1'b0, n_ef[63:32]};
                        if (r_off == 11'd7 && (w_eh < 33'h20 || w_eh > 33'h400 || w_eh > w_rem))
                            n_st = gfbar_pkg::ST_ENTRY;
                        if (r_off == 11'd11) begin
                            n_dstart = r_cursor + PW'(r_ef[42:32]);
                            w_dsum = {6'd0, r_total} - {6'd0, n_dstart};
                            w_end = ({8'd0, n_dstart} + {3'd0, n_ds} + 35'd7) & ~35'd7;
                            if ({1'b0, n_ds} > w_dsum) n_st = gfbar_pkg::ST_ENTRY;
                            else if (w_end <= {8'd0, r_cursor} || w_end > {8'd0, r_total})
                                n_st = gfbar_pkg::ST_ENTRY;
                            else n_nb = PW'(w_end);
                        end
                        if (n_st == gfbar_pkg::ST_OK) begin
                            if (r_off >= 11'h1c && r_off < 11'h1f) begin
                                n_held[8*r_off[1:0] +: 8] = i_byte;
                            end else if (r_off == 11'h1f) begin
                                w_arch = {i_byte, r_held};
                                w_bump[0] = 1'b1;
                                w_bump[1] = (w_kind == 16'd2);
                                w_bump[2] = (w_kind == 16'd1);
                                w_bump[3] = (w_arch == i_cfg.d);
                                w_bump[4] = (w_kind == 16'd2) && (w_arch == i_cfg.b);
                                w_bump[5] = (w_kind == 16'd2) && (w_arch == i_cfg.c);
                                w_retgt = (w_kind == 16'd2) && (w_arch == i_cfg.src)
                                          && i_cfg.mode[0];
                                w_out_arch = w_retgt ? i_cfg.tgt : w_arch;
                                if (w_retgt) begin
                                    w_bump[6] = (i_cfg.tgt == i_cfg.a);
                                    w_bump[7] = (i_cfg.tgt == i_cfg.b);
                                    if (i_cfg.mode[1] && r_ds >= 32'h34) n_fl[0] = 1'b1;
                                end
                                n_job.valid = 1'b1; n_job.nbytes = 3'd4;
                                n_job.bytes = w_out_arch;
                            end else begin
                                n_job.valid = 1'b1; n_job.nbytes = 3'd1; n_job.bytes[7:0] = w_b;
                            end
                            n_off = r_off + 11'd1;
                            if (r_off >= 11'h1f && {21'd0, r_off} + 32'd1 == r_ef[63:32]) begin
                                if (r_dstart >= r_nb) begin
                                    n_cursor = r_nb; n_off = '0; n_ef = '0; n_ds = '0;
                                    n_held = '0; n_fl = '0;
                                    n_phase = (r_nb >= r_total) ? gfbar_pkg::PH_DONE
                                                                : gfbar_pkg::PH_ENTRY;
                                end else n_phase = gfbar_pkg::PH_DATA;
                            end
                        end
                    end
                end
                gfbar_pkg::PH_DATA: begin
                    w_d = 32'(r_pos - r_dstart);
                    if (w_d < r_ds) begin
                        if (r_fl[0] && w_d < 32'd4) begin
                            unique case (w_d[1:0])
                                2'd0: n_fl[0] = (i_byte == 8'h7f);
                                2'd1: n_fl[0] = (i_byte == 8'h45);
                                2'd2: n_fl[0] = (i_byte == 8'h4c);
                                default: begin
                                    n_fl[0] = (i_byte == 8'h46);
                                    if (i_byte == 8'h46) begin
                                        n_fl[1] = 1'b1; w_bump[8] = 1'b1;
                                    end
                                end
                            endcase
                        end
                        if (r_fl[1] && w_d >= 32'h30 && w_d < 32'h34)
                            w_b = i_cfg.elf[8*w_d[1:0] +: 8];
                    end
                    n_job.valid = 1'b1; n_job.nbytes = 3'd1; n_job.bytes[7:0] = w_b;
                    if ({1'b0, r_pos} + 1 >= {1'b0, r_nb}) begin
                        n_cursor = r_nb; n_off = '0; n_ef = '0; n_ds = '0;
                        n_held = '0; n_fl = '0;
                        n_phase = (r_nb >= r_total) ? gfbar_pkg::PH_DONE
                                                    : gfbar_pkg::PH_ENTRY;
                    end
                end
                default: ;
            endcase
        end
        if (i_take && i_eob) begin
            if (w_pos1 < PW'(16)) w_fst = gfbar_pkg::ST_SHORT;
            else if (n_st == gfbar_pkg::ST_MAGIC || n_st == gfbar_pkg::ST_HSIZE) w_fst = n_st;
            else if (w_pos1 < n_total) w_fst = gfbar_pkg::ST_TRUNC;
            else if (n_st == gfbar_pkg::ST_ENTRY) w_fst = gfbar_pkg::ST_ENTRY;
            else if (r_cnt[0] == '0 && !w_bump[0]) w_fst = gfbar_pkg::ST_NOENT;
            else w_fst = gfbar_pkg::ST_OK;
            n_job.valid = 1'b1; n_job.report = 1'b1; n_job.status = w_fst;
            n_phase = gfbar_pkg::PH_HDR; n_pos = '0; n_total = '0; n_nb = '0;
            n_hlo = '0; n_hpay = '0; n_hsz = '0; n_dstart = '0; n_st = gfbar_pkg::ST_OK;
            n_cursor = '0; n_off = '0; n_ef = '0; n_ds = '0; n_held = '0; n_fl = '0;
        end
        if (!i_take) begin
            n_pos = r_pos;
            n_job = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= gfbar_pkg::PH_HDR; r_pos <= '0; r_total <= '0; r_cursor <= '0;
            r_dstart <= '0; r_nb <= '0; r_off <= '0; r_ef <= '0; r_ds <= '0;
            r_held <= '0; r_fl <= '0; r_hlo <= '0; r_hpay <= '0; r_hsz <= '0;
            r_st <= gfbar_pkg::ST_OK; o_job <= '0;
        end else begin
            r_phase <= n_phase; r_pos <= n_pos; r_total <= n_total; r_cursor <= n_cursor;
            r_dstart <= n_dstart; r_nb <= n_nb; r_off <= n_off; r_ef <= n_ef; r_ds <= n_ds;
            r_held <= n_held; r_fl <= n_fl; r_hlo <= n_hlo; r_hpay <= n_hpay;
            r_hsz <= n_hsz; r_st <= n_st; o_job <= n_job;
        end
    end

    // Counters are snapshotted into o_cnt on every take, alongside the job register, so the
    // live copy is cleared on the same end-of-buffer take that carries the report.
    for (genvar g = 0; g < gfbar_pkg::NCNT; g++) begin : g_cnt
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_cnt[g] <= '0;
            else if (i_take) begin
                if (i_eob) r_cnt[g] <= '0;
                else if (w_bump[g] && !i_clr_cnt) r_cnt[g] <= r_cnt[g] + CW'(1);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_take) o_cnt[g*CW +: CW] <= r_cnt[g] + CW'(w_bump[g]);
        end
    end
endmodule

// ===== src/gfbar_emit.sv =====
// Output sequencer: a two-deep job queue unrolled into result items on the master side.
// Depends on gfbar_pkg.
module gfbar_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gfbar_pkg::t_job      i_job,
    input  logic [gfbar_pkg::NCNT*gfbar_pkg::CNT_W-1:0] i_cnt,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_kind,
    output logic [3:0]           o_id,
    output logic [21:0]          o_value,
    output logic                 o_last
);
    localparam int unsigned CW = gfbar_pkg::CNT_W;
    localparam int unsigned JW = $bits(gfbar_pkg::t_job);
    localparam int unsigned QW = JW + gfbar_pkg::NCNT*CW;

    logic [QW-1:0] r_q [2];
    logic [1:0]    r_cnt_q;
    logic          r_rd;
    logic [3:0]    r_step;
    gfbar_pkg::t_job w_head;
    logic [gfbar_pkg::NCNT*CW-1:0] w_hcnt;
    logic [3:0] w_nb_steps, w_total;
    logic w_push, w_pop, w_fire;

    assign w_head = gfbar_pkg::t_job'(r_q[r_rd][QW-1 -: JW]);
    assign w_hcnt = r_q[r_rd][gfbar_pkg::NCNT*CW-1:0];
    assign w_nb_steps = {1'b0, w_head.nbytes};
    assign w_total = w_nb_steps + (w_head.report ? 4'd10 : 4'd0);
    assign o_valid = (r_cnt_q != 2'd0);
    assign w_fire  = o_valid && i_ready;
    assign w_pop   = w_fire && (r_step + 4'd1 == w_total);
    assign w_push  = i_job.valid;
    // Room is held for one job in flight plus the one being registered upstream.
    assign o_room  = (r_cnt_q == 2'd0) || (r_cnt_q == 2'd1 && (!i_job.valid || w_pop))
                     || (w_pop && !i_job.valid);

    always_comb begin
        o_kind = gfbar_pkg::KIND_BYTE; o_id = '0; o_value = '0; o_last = 1'b0;
        if (r_step < w_nb_steps) begin
            o_value = {14'd0, w_head.bytes[8*r_step[1:0] +: 8]};
        end else if (r_step - w_nb_steps < 4'd9) begin
            o_kind = gfbar_pkg::KIND_CNT;
            o_id = r_step - w_nb_steps;
            if (w_head.status == gfbar_pkg::ST_OK)
                o_value = w_hcnt[CW*(r_step - w_nb_steps) +: CW];
        end else begin
            o_kind = gfbar_pkg::KIND_STAT;
            o_value = {19'd0, w_head.status};
            o_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_q <= '0; r_rd <= 1'b0; r_step <= '0;
        end else begin
            if (w_pop) begin
                r_step <= '0; r_rd <= ~r_rd;
            end else if (w_fire) r_step <= r_step + 4'd1;
            r_cnt_q <= r_cnt_q + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_rd ^ r_cnt_q[0]] <= {i_job, i_cnt};
    end
endmodule

// ===== src/gpu_fat_binary_arch_rewriter.sv =====
// Top level of the fat-binary arch rewriter: APB registers, byte parser, output sequencer.
// Depends on gfbar_pkg, gfbar_regs, gfbar_parser and gfbar_emit.
//
//   channel   dir  fields
//   s_axis    in   tdata = data_byte[7:0], tuser = end_of_buffer
//   m_axis    out  tdata = value[21:0], tuser = result_kind[1:0], counter_id[5:2], tlast
//   apb       in   eight 32-bit registers at 4*i
//
// One byte per cycle enters while the output sequencer has room; each byte leaves zero to
// four items, or on the last byte up to fourteen items, which the sequencer drains one
// per cycle while m_axis_tready is high, so a report adds ten items. Reset is synchronous
// and clears all stream state and registers. A stall on the master side backs up into
// s_axis_tready through a two-job queue.
module gpu_fat_binary_arch_rewriter #(
    parameter int unsigned MAX_IMAGE_BYTES = gfbar_pkg::MAX_IMAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // end_of_buffer
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // value[21:0], zero fill
    output logic [5:0]  m_axis_tuser,   // result_kind[1:0], counter_id[5:2]
    output logic        m_axis_tlast,   // last_of_run
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    gfbar_pkg::t_cfg w_cfg;
    gfbar_pkg::t_job w_job;
    logic [gfbar_pkg::NCNT*gfbar_pkg::CNT_W-1:0] w_cnt;
    logic w_take, w_room;
    logic [1:0]  w_kind;
    logic [3:0]  w_id;
    logic [21:0] w_val;

    assign s_axis_tready = w_room;
    assign w_take = s_axis_tvalid && w_room;

    gfbar_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_cfg(w_cfg)
    );

    gfbar_parser #(.MAX_IMAGE_BYTES(MAX_IMAGE_BYTES)) u_parser (
        .i_clk, .i_rst_n, .i_take(w_take), .i_byte(s_axis_tdata), .i_eob(s_axis_tuser),
        .i_cfg(w_cfg), .i_clr_cnt(1'b0), .o_job(w_job), .o_cnt(w_cnt)
    );

    gfbar_emit u_emit (
        .i_clk, .i_rst_n, .i_job(w_job), .i_cnt(w_cnt), .o_room(w_room),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_kind(w_kind), .o_id(w_id),
        .o_value(w_val), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_val};
    assign m_axis_tuser = {w_id, w_kind};
endmodule

// ===== verif/tb_gpu_fat_binary_arch_rewriter.sv =====
// Testbench for gpu_fat_binary_arch_rewriter: streams container images through s_axis and
// checks every m_axis item against a behavioral predictor. Depends on gfbar_pkg and the RTL.
`timescale 1ns / 100ps
module tb_gpu_fat_binary_arch_rewriter;

    localparam int unsigned IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  id;
        logic [21:0] value;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [7:0] data;
        logic       eob;
    } t_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [5:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    gpu_fat_binary_arch_rewriter uut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state.
    gfbar_pkg::t_cfg cfg;
    logic [2:0]   ph;
    logic [31:0]  pos, img_total, ent_off, nxt_bnd, held, eflags, ent_dsize;
    logic [31:0]  cur, dstart, hsize;
    logic [63:0]  efields, hlo, hpay;
    logic [21:0]  cnt [gfbar_pkg::NCNT];
    logic [2:0]   stat;

    t_byte pending_bytes [$];
    t_res  expected_items [$];
    int    errors = 0;
    int    idle_cycles = 0;
    logic  in_fire = 1'b0;

    function automatic logic [2:0] gen_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return 7;
    endfunction

    task automatic push_item(logic [1:0] k, logic [3:0] i, logic [21:0] v, logic l);
        t_res r;
        r.kind = k; r.id = i; r.value = v; r.last = l;
        expected_items.push_back(r);
    endtask

    task automatic bump(int i);
        cnt[i] = cnt[i] + 1'b1;
    endtask

    task automatic begin_entry(logic [31:0] c);
        cur = c; ent_off = 0; efields = 0; ent_dsize = 0; held = 0; eflags = 0;
        ph = (c >= img_total) ? gfbar_pkg::PH_DONE : gfbar_pkg::PH_ENTRY;
    endtask

    task automatic clear_stream();
        pos = 0; img_total = 0; nxt_bnd = 0; hlo = 0; hpay = 0; hsize = 0; dstart = 0;
        for (int i = 0; i < gfbar_pkg::NCNT; i++) cnt[i] = '0;
        stat = gfbar_pkg::ST_OK;
        begin_entry(0);
        ph = gfbar_pkg::PH_HDR;
    endtask

    task automatic finish_arch(logic [31:0] arch);
        logic [15:0] k;
        k = efields[15:0];
        bump(0);
        if (k == 2) bump(1);
        if (k == 1) bump(2);
        if (arch == cfg.d) bump(3);
        if (k == 2 && arch == cfg.b) bump(4);
        if (k == 2 && arch == cfg.c) bump(5);
        if (k == 2 && arch == cfg.src && cfg.mode[0]) begin
            arch = cfg.tgt;
            if (cfg.tgt == cfg.a) bump(6);
            if (cfg.tgt == cfg.b) bump(7);
            if (cfg.mode[1] && ent_dsize >= 32'h34) eflags[0] = 1'b1;
        end
        for (int i = 0; i < 4; i++) push_item(gfbar_pkg::KIND_BYTE, 0, arch[8*i +: 8], 0);
    endtask

    task automatic parse_byte(logic [7:0] b, logic [31:0] p);
        logic [31:0] off, eh, d;
        logic [63:0] fin;
        logic [7:0]  em [4];
        em[0] = 8'h7f; em[1] = 8'h45; em[2] = 8'h4c; em[3] = 8'h46;
        case (ph)
            gfbar_pkg::PH_HDR: begin
                if (p < 8) hlo[8*p +: 8] = b;
                else hpay[8*(p-8) +: 8] = b;
                if (p == 3 && hlo[31:0] != gfbar_pkg::IMG_MAGIC) begin
                    stat = gfbar_pkg::ST_MAGIC; return;
                end
                if (p == 7) begin
                    hsize = hlo[63:48];
                    if (hsize < 16 || hsize > 256) begin
                        stat = gfbar_pkg::ST_HSIZE; return;
                    end
                end
                if (p == 15) begin
                    if (hpay > gfbar_pkg::MAX_IMAGE_BYTES_DEF) begin
                        stat = gfbar_pkg::ST_HSIZE; return;
                    end
                    img_total = hsize + hpay[31:0];
                    push_item(gfbar_pkg::KIND_BYTE, 0, b, 0);
                    if (hsize == 16) begin_entry(16);
                    else ph = gfbar_pkg::PH_HDRPAD;
                    return;
                end
                push_item(gfbar_pkg::KIND_BYTE, 0, b, 0);
            end
            gfbar_pkg::PH_HDRPAD: begin
                push_item(gfbar_pkg::KIND_BYTE, 0, b, 0);
                if (p + 1 >= hsize) begin_entry(hsize);
            end
            gfbar_pkg::PH_ENTRY: begin
                off = ent_off;
                if (off == 0 && img_total - cur < 32) begin
                    stat = gfbar_pkg::ST_ENTRY; return;
                end
                if (off < 8) efields[8*off +: 8] = b;
                else if (off < 12) ent_dsize[8*(off-8) +: 8] = b;
                eh = efields[63:32];
                if (off == 7 && (eh < 32 || eh > 1024 || eh > img_total - cur)) begin
                    stat = gfbar_pkg::ST_ENTRY; return;
                end
                if (off == 11) begin
                    dstart = cur + eh;
                    if (ent_dsize > img_total - dstart) begin
                        stat = gfbar_pkg::ST_ENTRY; return;
                    end
                    fin = ({32'h0, dstart} + {32'h0, ent_dsize} + 64'd7) & ~64'd7;
                    if (fin <= {32'h0, cur} || fin > {32'h0, img_total}) begin
                        stat = gfbar_pkg::ST_ENTRY; return;
                    end
                    nxt_bnd = fin[31:0];
                end
                if (off >= 28 && off < 31) held[8*(off-28) +: 8] = b;
                else if (off == 31) finish_arch({b, held[23:0]});
                else push_item(gfbar_pkg::KIND_BYTE, 0, b, 0);
                ent_off = (off + 1) & 32'h7ff;
                if (off >= 31 && off + 1 == eh) begin
                    if (dstart >= nxt_bnd) begin_entry(nxt_bnd);
                    else ph = gfbar_pkg::PH_DATA;
                end
            end
            gfbar_pkg::PH_DATA: begin
                if (p - dstart < ent_dsize) begin
                    d = p - dstart;
                    if (eflags[0] && d < 4) begin
                        if (b != em[d]) eflags[0] = 1'b0;
                        else if (d == 3) begin
                            eflags[1] = 1'b1; bump(8);
                        end
                    end
                    if (eflags[1] && d >= 48 && d < 52) b = cfg.elf[8*(d-48) +: 8];
                end
                push_item(gfbar_pkg::KIND_BYTE, 0, b, 0);
                if (p + 1 >= nxt_bnd) begin_entry(nxt_bnd);
            end
            default: ;
        endcase
    endtask

    task automatic predict_byte(t_byte it);
        logic [31:0] p;
        logic [2:0]  st;
        p = pos;
        if (pos < 32'h7ffffff) pos = pos + 1;
        if (stat == gfbar_pkg::ST_OK) parse_byte(it.data, p);
        if (it.eob) begin
            if (pos < 16) st = gfbar_pkg::ST_SHORT;
            else if (stat == gfbar_pkg::ST_MAGIC || stat == gfbar_pkg::ST_HSIZE) st = stat;
            else if (pos < img_total) st = gfbar_pkg::ST_TRUNC;
            else if (stat == gfbar_pkg::ST_ENTRY) st = gfbar_pkg::ST_ENTRY;
            else if (cnt[0] == 0) st = gfbar_pkg::ST_NOENT;
            else st = gfbar_pkg::ST_OK;
            for (int i = 0; i < gfbar_pkg::NCNT; i++)
                push_item(gfbar_pkg::KIND_CNT, i, st == gfbar_pkg::ST_OK ? cnt[i] : 22'd0, 0);
            push_item(gfbar_pkg::KIND_STAT, 0, st, 1);
            clear_stream();
        end
    endtask

    // Driver: one byte from the queue, random gaps between items.
    logic [2:0] in_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && in_fire) begin
                void'(pending_bytes.pop_front());
                in_gap = gen_gap();
            end else if (s_axis_tvalid) begin
                // hold
            end
            if (!(s_axis_tvalid && !in_fire)) begin
                if (in_gap != 0 || pending_bytes.size() == 0) begin
                    if (in_gap != 0) in_gap = in_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_bytes[0].data;
                    s_axis_tuser  <= pending_bytes[0].eob;
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) < 12) ? 1'b0 : 1'b1;
        end
    end

    // Monitor: predicts on accepted input, checks accepted output.
    always @(posedge i_clk) begin
        t_byte in_it;
        t_res  exp_r, got;
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_axis_tvalid && s_axis_tready) begin
                in_it.data = s_axis_tdata;
                in_it.eob  = s_axis_tuser;
                predict_byte(in_it);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind = m_axis_tuser[1:0];
                got.id = m_axis_tuser[5:2];
                got.value = m_axis_tdata[21:0];
                got.last = m_axis_tlast;
                if (expected_items.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item %h", $realtime, got);
                end else begin
                    exp_r = expected_items.pop_front();
                    if (got !== exp_r) begin
                        errors++;
                        $display("%0t: mismatch expected kind %0d id %0d value %h last %0d,",
                            $realtime, exp_r.kind, exp_r.id, exp_r.value, exp_r.last);
                        $display("    actual kind %0d id %0d value %h last %0d",
                            got.kind, got.id, got.value, got.last);
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            gfbar_pkg::REG_MODE: cfg.mode = v[1:0];
            gfbar_pkg::REG_SRC:  cfg.src = v;
            gfbar_pkg::REG_TGT:  cfg.tgt = v;
            gfbar_pkg::REG_ELF:  cfg.elf = v;
            gfbar_pkg::REG_A:    cfg.a = v;
            gfbar_pkg::REG_B:    cfg.b = v;
            gfbar_pkg::REG_C:    cfg.c = v;
            default:             cfg.d = v;
        endcase
    endtask

    task automatic put_b(logic [7:0] b, logic e = 0);
        t_byte t;
        t.data = b; t.eob = e;
        pending_bytes.push_back(t);
    endtask

    task automatic put_w(logic [31:0] w, int n);
        for (int i = 0; i < n; i++) put_b(w[8*i +: 8]);
    endtask

    // Builds one image of nent entries; kinds random, arch mostly picked from the cfg mirror.
    // Optional defects: 1 bad magic, 2 bad header size, 3 truncate, 4 bad entry size,
    // 5 trailing bytes, 6 random noise byte flip. Header defects stop after the base header.
    task automatic build_image(int nent, int defect);
        logic [31:0] hs, esz [8], eh [8], kd [8], ar [8], pay, total;
        int cut;
        hs = ($urandom_range(0, 3) == 0) ? 16 + 8 * $urandom_range(0, 10) : 16;
        pay = 0;
        for (int e = 0; e < nent; e++) begin
            eh[e] = ($urandom_range(0, 4) == 0) ? 32 + 8 * $urandom_range(0, 4) : 32;
            esz[e] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 20) : $urandom_range(52, 70);
            kd[e] = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : 2;
            case ($urandom_range(0, 4))
                0: ar[e] = cfg.b;
                1: ar[e] = cfg.c;
                2: ar[e] = cfg.d;
                3: ar[e] = $urandom;
                default: ar[e] = cfg.src;
            endcase
            pay += eh[e] + ((esz[e] + 7) & ~32'd7);
        end
        total = hs + pay;
        if (defect == 1 || defect == 2) cut = 16;
        else cut = (defect == 3) ? $urandom_range(1, total - 1)
                                 : total + ((defect == 5) ? 5 : 0);
        begin
            t_byte img [$];
            logic [31:0] w;
            t_byte t;
            w = (defect == 1) ? gfbar_pkg::IMG_MAGIC ^ (1 << $urandom_range(0, 31))
                              : gfbar_pkg::IMG_MAGIC;
            for (int i = 0; i < 4; i++) begin t.data = w[8*i +: 8]; t.eob = 0; img.push_back(t); end
            w = {(defect == 2) ? 16'(16'h0101 + $urandom_range(0, 255)) : hs[15:0],
                 16'($urandom)};
            for (int i = 0; i < 4; i++) begin t.data = w[8*i +: 8]; img.push_back(t); end
            for (int i = 0; i < 8; i++) begin t.data = (i < 4) ? pay[8*i +: 8] : 0; img.push_back(t); end
            for (int i = 16; i < hs; i++) begin t.data = $urandom; img.push_back(t); end
            for (int e = 0; e < nent; e++) begin
                for (int i = 0; i < eh[e]; i++) begin
                    if (i < 2) t.data = kd[e][8*i +: 8];
                    else if (i >= 4 && i < 8) t.data = eh[e][8*(i-4) +: 8];
                    else if (i >= 8 && i < 12)
                        t.data = (defect == 4 && e == 0) ? 8'hff : esz[e][8*(i-8) +: 8];
                    else if (i >= 28 && i < 32) t.data = ar[e][8*(i-28) +: 8];
                    else t.data = $urandom;
                    img.push_back(t);
                end
                for (int i = 0; i < ((esz[e] + 7) & ~32'd7); i++) begin
                    if (i < 4 && $urandom_range(0, 3) != 0)
                        t.data = (i == 0) ? 8'h7f : (i == 1) ? 8'h45 : (i == 2) ? 8'h4c : 8'h46;
                    else t.data = $urandom;
                    img.push_back(t);
                end
            end
            while (img.size() < cut) begin t.data = $urandom; img.push_back(t); end
            if (defect == 6) img[$urandom_range(0, img.size() - 1)].data ^= 8'($urandom_range(1, 255));
            for (int i = 0; i < cut && i < img.size(); i++) begin
                put_b(img[i].data, i == cut - 1);
            end
        end
    endtask

    task automatic drain();
        while (!(pending_bytes.size() == 0 && !s_axis_tvalid && expected_items.size() == 0))
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    initial begin
        int sent;
        cfg = '0;
        clear_stream();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: lone end marker on a zero byte, short all-ones image, image with no entries.
        put_b(8'h00, 1);
        for (int i = 0; i < 10; i++) put_b(8'hff, i == 9);
        build_image(0, 0);
        drain();

        apb_write(gfbar_pkg::REG_MODE, 32'h3);
        apb_write(gfbar_pkg::REG_SRC, 32'h56);
        apb_write(gfbar_pkg::REG_TGT, 32'h4b);
        apb_write(gfbar_pkg::REG_ELF, 32'hffffffff);
        apb_write(gfbar_pkg::REG_A, 32'h4b);
        apb_write(gfbar_pkg::REG_B, 32'h4b);
        apb_write(gfbar_pkg::REG_C, 32'h59);
        apb_write(gfbar_pkg::REG_D, 32'h78);
        build_image(0, 1);
        build_image(0, 2);
        drain();

        sent = 0;
        for (int ph_i = 0; ph_i < 3; ph_i++) begin
            apb_write(gfbar_pkg::REG_MODE, (ph_i + 1) % 4);
            apb_write(gfbar_pkg::REG_SRC, ph_i == 1 ? 32'hffffffff : $urandom);
            apb_write(gfbar_pkg::REG_TGT, ph_i == 1 ? 32'h0 : $urandom);
            apb_write(gfbar_pkg::REG_ELF, ph_i == 2 ? 32'h0 : $urandom);
            apb_write(gfbar_pkg::REG_A, $urandom_range(0, 1) ? cfg.tgt : $urandom);
            apb_write(gfbar_pkg::REG_B, $urandom);
            apb_write(gfbar_pkg::REG_C, ph_i == 1 ? 32'hffffffff : $urandom);
            apb_write(gfbar_pkg::REG_D, $urandom);
            repeat (1) begin
                int base_size;
                base_size = pending_bytes.size();
                while (pending_bytes.size() - base_size < 70) begin
                    int r;
                    r = $urandom_range(0, 9);
                    build_image(1, r < 6 ? 0 : $urandom_range(1, 6));
                end
                sent += pending_bytes.size() - base_size;
            end
            drain();
        end
        if (errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== gpu_fat_binary_arch_rewriter.f =====
src/gfbar_pkg.sv
src/gfbar_regs.sv
src/gfbar_parser.sv
src/gfbar_emit.sv
src/gpu_fat_binary_arch_rewriter.sv
verif/tb_gpu_fat_binary_arch_rewriter.sv
